// File: rtl/lcr_pkg.sv
// Shared types, codes and constants for the load cell reader.
`default_nettype none

package lcr_pkg;

	localparam int TareSamplesDef = 10;
	localparam int CodeBitsDef    = 24;

	localparam int CodeW     = 24;
	localparam int TareSumW  = 28;
	localparam int TareCntW  = 4;
	localparam int WeightW   = 32;
	localparam int ScaleW    = 32;
	localparam int TimeoutW  = 24;
	localparam int FaultW    = 8;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 32;

	localparam logic [CodeW-1:0]    OverloadLimit = 24'd8388607;
	localparam logic [ScaleW-1:0]   ScaleOne      = 32'd65536;
	localparam logic [TimeoutW-1:0] TimeoutRst    = 24'd1000000;
	localparam logic [FaultW-1:0]   MaxFaultsRst  = 8'd5;
	localparam logic [FaultW-1:0]   FaultSat      = 8'd255;

	typedef enum logic [1:0] {
		OpTick  = 2'd0,
		OpRead  = 2'd1,
		OpTare  = 2'd2,
		OpClear = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		StNone     = 3'd0,
		StOk       = 3'd1,
		StNotTared = 3'd2,
		StNoData   = 3'd3,
		StOverload = 3'd4,
		StTareDone = 3'd5
	} status_t;

	typedef enum logic [CfgIdxW-1:0] {
		RegScale    = 2'd0,
		RegTimeout  = 2'd1,
		RegMaxFault = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       dt_level;
	} in_beat_t;

	typedef struct packed {
		logic               sck_level;
		logic [2:0]         reading_status;
		logic [WeightW-1:0] weight;
		logic [CodeW-1:0]   raw_code;
		logic [FaultW-1:0]  fault_count;
		logic               in_error;
		logic               tared_flag;
		logic               busy_res;
	} out_beat_t;

endpackage

`default_nettype wire

// File: rtl/lcr_if.sv
// Valid/ready channel interfaces for input ticks and result beats.
`default_nettype none

interface lcr_in_if;
	logic             valid;
	logic             ready;
	lcr_pkg::in_beat_t beat;
	modport source (output valid, output beat, input ready);
	modport sink   (input valid, input beat, output ready);
endinterface

interface lcr_out_if;
	logic               valid;
	logic               ready;
	lcr_pkg::out_beat_t beat;
	modport source (output valid, output beat, input ready);
	modport sink   (input valid, input beat, output ready);
endinterface

`default_nettype wire

// File: rtl/load_cell_reader_tare_scale.sv
// Load cell reader: serial converter sequencer with tare, offset and scaling.
//
// Usage: each beat on in_ch is one tick (half a serial clock period) carrying
// a command and the sampled data line level. Every accepted tick gives exactly
// one beat on out_ch with the clock level to drive, a status, the last weight,
// the raw code of a read ending on that tick, the fault count and flags.
// Registers (scale, timeout, fault limit) are written through cfg_we, cfg_index
// and cfg_data, by the user only while no tick is in flight; not enforced here.
// A tick goes through one input stage and one result register to its result
// beat. Throughput is one tick per cycle while out_ch does not stall; the whole state
// update, the 25x32 weight multiply and the tare mean (a reciprocal multiply)
// sit between those two registers.
// When out_ch stalls, the result register holds its beat; the input stage can
// still take one tick, then in_ch drops ready until out_ch drains.
// Reset clears all state but the payload registers: idle, not tared, unity
// scale, 1000000-tick timeout, fault limit 5.
`default_nettype none

module load_cell_reader_tare_scale #(
	parameter int TARE_SAMPLES = lcr_pkg::TareSamplesDef,
	parameter int CODE_BITS    = lcr_pkg::CodeBitsDef
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	lcr_in_if.sink                            in_ch,
	lcr_out_if.source                         out_ch,
	input  wire logic                         cfg_we,
	input  wire logic [lcr_pkg::CfgIdxW-1:0]  cfg_index,
	input  wire logic [lcr_pkg::CfgDataW-1:0] cfg_data
);

	localparam int CodeW   = lcr_pkg::CodeW;
	localparam int SumW    = lcr_pkg::TareSumW;
	localparam int TcntW   = lcr_pkg::TareCntW;
	localparam int BitW    = $clog2(CODE_BITS + 2);
	localparam int ProdW   = CodeW + 1 + lcr_pkg::ScaleW;
	localparam logic [BitW-1:0]  CodeBitsN = BitW'(CODE_BITS);
	localparam logic [BitW-1:0]  LastBit   = BitW'(CODE_BITS + 1);
	localparam logic [TcntW-1:0] TareN     = TcntW'(TARE_SAMPLES);

	typedef enum logic [2:0] {
		PhIdle  = 3'd0,
		PhRwait = 3'd1,
		PhRclk  = 3'd2,
		PhTwait = 3'd3,
		PhTclk  = 3'd4
	} phase_t;

	// input stage and result register
	logic               valid_s1;
	lcr_pkg::in_beat_t  beat_s1;
	logic               out_valid_q;
	lcr_pkg::out_beat_t out_beat_q;
	logic               adv;

	// block state
	phase_t                        phase_q,  phase_d;
	logic [lcr_pkg::TimeoutW-1:0]  wait_q,   wait_d;
	logic [BitW-1:0]               bit_q,    bit_d;
	logic [CodeW-1:0]              shift_q,  shift_d;
	logic                          clk_out_q, clk_out_d;
	logic [CodeW-1:0]              offset_q, offset_d;
	logic [SumW-1:0]               sum_q,    sum_d;
	logic [TcntW-1:0]              tcnt_q,   tcnt_d;
	logic                          tared_q,  tared_d;
	logic [lcr_pkg::FaultW-1:0]    fail_q,   fail_d;
	logic [lcr_pkg::WeightW-1:0]   lw_q,     lw_d;
	logic signed [lcr_pkg::ScaleW-1:0] scale_q,  scale_d;
	logic [lcr_pkg::TimeoutW-1:0]  timeout_q;
	logic [lcr_pkg::FaultW-1:0]    maxf_q;

	logic [CodeW-1:0]   tare_mean;
	lcr_pkg::out_beat_t res;

	// weight datapath
	logic [CodeW-1:0]             offset_rd;
	logic signed [CodeW:0]        diff;
	logic signed [ProdW-1:0]      prod;
	logic [lcr_pkg::WeightW-1:0]  wgt;

	logic                         fin;
	logic                         fin_tare;
	logic                         fault;
	logic [CodeW-1:0]             fin_code;
	logic [SumW-1:0]              sum_new;
	logic [TcntW-1:0]             tcnt_new;
	logic [lcr_pkg::TimeoutW-1:0] wait_inc;
	logic [BitW-1:0]              bit_inc;
	logic                         is_clear;

	assign adv         = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || adv;
	assign out_ch.valid = out_valid_q;
	assign out_ch.beat  = out_beat_q;

	// a timed-out tare read adds zero
	assign sum_new = sum_q + SumW'((phase_q == PhTclk) ? shift_q : '0);

	lcr_div #(
		.TARE_SAMPLES(TARE_SAMPLES)
	) u_div (
		.dividend(sum_new),
		.quotient(tare_mean)
	);

	assign is_clear  = (beat_s1.operation == lcr_pkg::OpClear);
	assign offset_rd = is_clear ? '0 : offset_q;

	always_comb begin
		diff = $signed({1'b0, shift_q}) - $signed({1'b0, offset_rd});
		prod = ProdW'(diff) * ProdW'(scale_d);
		wgt  = '0;
		if (prod > 0) begin
			if (|prod[ProdW-1:16+lcr_pkg::WeightW]) begin
				wgt = '1;
			end else begin
				wgt = prod[16 +: lcr_pkg::WeightW];
			end
		end
	end

	always_comb begin
		phase_d   = phase_q;
		wait_d    = wait_q;
		bit_d     = bit_q;
		shift_d   = shift_q;
		clk_out_d = clk_out_q;
		offset_d  = offset_q;
		sum_d     = sum_q;
		tcnt_d    = tcnt_q;
		tared_d   = tared_q;
		fail_d    = fail_q;
		lw_d      = lw_q;
		scale_d   = scale_q;
		fin       = 1'b0;
		fin_tare  = (phase_q == PhTwait) || (phase_q == PhTclk);
		fin_code  = '0;
		fault     = 1'b0;
		wait_inc  = wait_q + lcr_pkg::TimeoutW'(1);
		bit_inc   = bit_q + BitW'(1);
		tcnt_new  = '0;
		res       = '0;
		res.reading_status = lcr_pkg::StNone;

		if (is_clear) begin
			offset_d = '0;
			scale_d  = lcr_pkg::ScaleOne;
			tared_d  = 1'b0;
			fail_d   = '0;
			lw_d     = '0;
		end

		case (phase_q)
			PhIdle: begin
				clk_out_d = 1'b0;
				if (beat_s1.operation == lcr_pkg::OpRead) begin
					if (tared_d) begin
						phase_d = PhRwait;
						wait_d  = '0;
						bit_d   = '0;
						shift_d = '0;
					end else begin
						res.reading_status = lcr_pkg::StNotTared;
					end
				end else if (beat_s1.operation == lcr_pkg::OpTare) begin
					sum_d   = '0;
					tcnt_d  = '0;
					phase_d = PhTwait;
					wait_d  = '0;
					bit_d   = '0;
					shift_d = '0;
				end
			end
			PhRwait, PhTwait: begin
				if (!beat_s1.dt_level) begin
					phase_d   = (phase_q == PhTwait) ? PhTclk : PhRclk;
					bit_d     = '0;
					shift_d   = '0;
					clk_out_d = 1'b0;
				end else begin
					wait_d = wait_inc;
					fin    = (wait_inc >= timeout_q);
				end
			end
			PhRclk, PhTclk: begin
				if (!clk_out_q) begin
					clk_out_d     = 1'b1;
					res.sck_level = 1'b1;
					if (bit_q < CodeBitsN) begin
						shift_d = {shift_q[CodeW-2:0], beat_s1.dt_level};
					end
				end else begin
					clk_out_d = 1'b0;
					bit_d     = bit_inc;
					if (bit_inc >= LastBit) begin
						fin      = 1'b1;
						fin_code = shift_q;
					end
				end
			end
			default: begin
				phase_d = PhIdle;
			end
		endcase

		if (fin) begin
			if (fin_tare) begin
				tcnt_new = tcnt_q + TcntW'(1);
				if (tcnt_new >= TareN) begin
					offset_d = tare_mean;
					tared_d  = 1'b1;
					sum_d    = '0;
					tcnt_d   = '0;
					phase_d  = PhIdle;
					res.reading_status = lcr_pkg::StTareDone;
				end else begin
					sum_d     = sum_new;
					tcnt_d    = tcnt_new;
					phase_d   = PhTwait;
					wait_d    = '0;
					bit_d     = '0;
					shift_d   = '0;
					clk_out_d = 1'b0;
				end
			end else begin
				phase_d = PhIdle;
				if (fin_code == '0) begin
					fault = 1'b1;
					res.reading_status = lcr_pkg::StNoData;
				end else if (fin_code > lcr_pkg::OverloadLimit) begin
					fault = 1'b1;
					res.reading_status = lcr_pkg::StOverload;
				end else begin
					lw_d   = wgt;
					fail_d = '0;
					res.reading_status = lcr_pkg::StOk;
				end
			end
		end
		if (fault && (fail_d != lcr_pkg::FaultSat)) begin
			fail_d = fail_d + lcr_pkg::FaultW'(1);
		end

		res.weight      = lw_d;
		res.raw_code    = fin_code;
		res.fault_count = fail_d;
		res.in_error    = (fail_d >= maxf_q);
		res.tared_flag  = tared_d;
		res.busy_res    = (phase_d != PhIdle);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PhIdle;
			wait_q      <= '0;
			bit_q       <= '0;
			shift_q     <= '0;
			clk_out_q   <= 1'b0;
			offset_q    <= '0;
			sum_q       <= '0;
			tcnt_q      <= '0;
			tared_q     <= 1'b0;
			fail_q      <= '0;
			lw_q        <= '0;
			scale_q     <= lcr_pkg::ScaleOne;
			timeout_q   <= lcr_pkg::TimeoutRst;
			maxf_q      <= lcr_pkg::MaxFaultsRst;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end

			if (adv) begin
				phase_q   <= phase_d;
				wait_q    <= wait_d;
				bit_q     <= bit_d;
				shift_q   <= shift_d;
				clk_out_q <= clk_out_d;
				sum_q     <= sum_d;
				tcnt_q    <= tcnt_d;
				tared_q   <= tared_d;
				fail_q    <= fail_d;
				lw_q      <= lw_d;
				offset_q  <= offset_d;
				scale_q   <= scale_d;
			end

			if (cfg_we) begin
				case (cfg_index)
					lcr_pkg::RegScale:    scale_q   <= cfg_data;
					lcr_pkg::RegTimeout:  timeout_q <= cfg_data[lcr_pkg::TimeoutW-1:0];
					lcr_pkg::RegMaxFault: maxf_q    <= cfg_data[lcr_pkg::FaultW-1:0];
					default: begin
					end
				endcase
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			beat_s1 <= in_ch.beat;
		end
		if (adv) begin
			out_beat_q <= res;
		end
	end

endmodule

`default_nettype wire

// File: rtl/lcr_div.sv
// Tare mean: sample sum divided by the sample count with a reciprocal multiply.
`default_nettype none

module lcr_div #(
	parameter int TARE_SAMPLES = lcr_pkg::TareSamplesDef
) (
	input  wire logic [lcr_pkg::TareSumW-1:0] dividend,
	output logic      [lcr_pkg::CodeW-1:0]    quotient
);

	localparam int SumW  = lcr_pkg::TareSumW;
	localparam int RecW  = SumW + 1;
	localparam int ProdW = SumW + RecW;
	// exact floor division for any dividend below 2**SumW
	localparam int Shift = SumW + $clog2(TARE_SAMPLES);
	localparam longint unsigned RecipFull =
		((64'd1 << Shift) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
	localparam logic [RecW-1:0] Recip = RecW'(RecipFull);

	logic [ProdW-1:0] prod;

	assign prod     = ProdW'(dividend) * ProdW'(Recip);
	assign quotient = prod[Shift +: lcr_pkg::CodeW];

endmodule

`default_nettype wire
